>>> src/rqps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqps_pkg: shared types and constants for the ready queue scheduler
// Operation and policy codes, field widths and default sizes.
// ---------------------------------------------------------------------------
package rqps_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int ID_PORT_W = 8;
  localparam int PRIO_W    = 8;
  localparam int SIZE_W    = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MARK  = 2'd1,
    OP_SCHED = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_RR   = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_SJF  = 2'd3
  } mode_e;

endpackage

>>> src/rqps_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqps_ram: simple dual port RAM
// One write port, one read port, read data registered (old data on a
// same-address write).
// ---------------------------------------------------------------------------
module rqps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ready_queue_process_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ready_queue_process_scheduler: ordered ready queue with four policies
// Jobs live in one RAM word each; a small sequencer walks the RAM one entry
// per cycle for marking, compaction and rotation, and also runs an insertion sort.
// ---------------------------------------------------------------------------
// Usage:
//   A command word (op, job fields) is taken when start is high and busy is
//   low. Every command returns exactly one result word, shown on granted_o,
//   granted_id_o and rejected_o for one cycle with result_valid_o high.
//   The receiver cannot stall; the result is not held.
//   The user writes policy_mode over cfg_valid_i/cfg_ready_o only while idle; the block does not enforce it.
// Sequencing (through the single RAM port pair):
//   add, clear: result in the cycle after start.
//   mark:       one RAM read per entry.
//   schedule:   a compaction pass, then for priority and shortest job
//               an insertion sort when more than one entry is left,
//               then a fetch of the head; outside first come, with more
//               than one entry, the head is rotated to the back.
//   busy is high from the cycle after start until the result cycle; add and
//   clear never raise it. The next command may start in the cycle that
//   shows the result.
// Reset: queue empty, all marks clear, policy first come; no clearing pass.
// ---------------------------------------------------------------------------
module ready_queue_process_scheduler
  import rqps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op_i,
  input  logic [ID_PORT_W-1:0] job_id_i,
  input  logic [PRIO_W-1:0]    job_priority_i,
  input  logic [SIZE_W-1:0]    job_size_i,
  output logic                 result_valid_o,
  output logic                 granted_o,
  output logic [ID_PORT_W-1:0] granted_id_o,
  output logic                 rejected_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_data_i
);

  localparam int IdW   = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
  localparam int WordW = IdW + PRIO_W + SIZE_W;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW  = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MARK,
    S_PACK,
    S_SRT_RD,
    S_SRT_KEY,
    S_SRT_CMP,
    S_SRT_PUT,
    S_HEAD_RD,
    S_GRANT,
    S_ROT,
    S_ROT_PUT
  } state_e;

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [QUEUE_DEPTH-1:0] term_q, term_d;
  logic [IdW-1:0]         id_q, id_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        w_q, w_d;
  logic [CntW-1:0]        j_q, j_d;
  logic [WordW-1:0]       key_q, key_d;
  logic                   found_q, found_d;
  logic                   res_valid_q, res_valid_d;
  logic                   granted_q, granted_d;
  logic [ID_PORT_W-1:0]   gid_q, gid_d;
  logic                   rejected_q, rejected_d;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic [IdW-1:0]    rd_id;
  logic [PRIO_W-1:0] rd_prio, key_prio;
  logic [SIZE_W-1:0] rd_size, key_size;
  logic [CntW-1:0]   idx_inc, idx_dec, j_dec, j_dec2, w_inc, cnt_dec;
  logic              match, found_nxt, keep, key_first;

  assign rd_id    = ram_rdata[WordW-1 -: IdW];
  assign rd_prio  = ram_rdata[SIZE_W +: PRIO_W];
  assign rd_size  = ram_rdata[SIZE_W-1:0];
  assign key_prio = key_q[SIZE_W +: PRIO_W];
  assign key_size = key_q[SIZE_W-1:0];

  assign idx_inc = idx_q + 1'b1;
  assign idx_dec = idx_q - 1'b1;
  assign j_dec   = j_q - 1'b1;
  assign j_dec2  = j_q - 2'd2;
  assign cnt_dec = count_q - 1'b1;

  assign match     = (rd_id == id_q);
  assign found_nxt = found_q | match;
  assign keep      = ~term_q[idx_q[IdxW-1:0]];
  assign w_inc     = w_q + CntW'(keep);
  // stable insertion: key moves ahead only on a strict win
  assign key_first = (mode_q == MODE_PRIO) ? (key_prio > rd_prio) : (key_size < rd_size);

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    term_d      = term_q;
    id_d        = id_q;
    idx_d       = idx_q;
    w_d         = w_q;
    j_d         = j_q;
    key_d       = key_q;
    found_d     = found_q;
    res_valid_d = 1'b0;
    granted_d   = granted_q;
    gid_d       = gid_q;
    rejected_d  = rejected_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = key_q;
    ram_raddr   = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = mode_e'(cfg_data_i);
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          granted_d  = 1'b0;
          gid_d      = '0;
          rejected_d = 1'b0;
          id_d       = job_id_i[IdW-1:0];
          idx_d      = '0;
          w_d        = '0;
          found_d    = 1'b0;
          case (op_e'(op_i))
            OP_ADD: begin
              res_valid_d = 1'b1;
              if (count_q == CntW'(QUEUE_DEPTH)) begin
                rejected_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IdxW-1:0];
                ram_wdata = {job_id_i[IdW-1:0], job_priority_i, job_size_i};
                term_d[count_q[IdxW-1:0]] = 1'b0;
                count_d   = count_q + 1'b1;
              end
            end
            OP_MARK: begin
              if (count_q == '0) begin
                rejected_d  = 1'b1;
                res_valid_d = 1'b1;
              end else begin
                state_d = S_MARK;
              end
            end
            OP_SCHED: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = S_PACK;
              end
            end
            OP_CLEAR: begin
              count_d     = '0;
              term_d      = '0;
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_MARK: begin
        term_d[idx_q[IdxW-1:0]] = term_q[idx_q[IdxW-1:0]] | match;
        found_d   = found_nxt;
        ram_raddr = idx_inc[IdxW-1:0];
        idx_d     = idx_inc;
        if (idx_inc == count_q) begin
          rejected_d  = ~found_nxt;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // compaction: write pointer never passes the read pointer
      S_PACK: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = w_q[IdxW-1:0];
          ram_wdata = ram_rdata;
        end
        w_d       = w_inc;
        ram_raddr = idx_inc[IdxW-1:0];
        idx_d     = idx_inc;
        if (idx_inc == count_q) begin
          count_d = w_inc;
          term_d  = '0;
          if (w_inc == '0) begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if ((mode_q == MODE_PRIO || mode_q == MODE_SJF) && w_inc > CntW'(1)) begin
            idx_d   = CntW'(1);
            state_d = S_SRT_RD;
          end else begin
            state_d = S_HEAD_RD;
          end
        end
      end

      S_SRT_RD: begin
        ram_raddr = idx_q[IdxW-1:0];
        state_d   = S_SRT_KEY;
      end

      S_SRT_KEY: begin
        key_d     = ram_rdata;
        j_d       = idx_q;
        ram_raddr = idx_dec[IdxW-1:0];
        state_d   = S_SRT_CMP;
      end

      // ram_rdata holds entry j-1; slot j is free
      S_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IdxW-1:0];
        if (key_first) begin
          ram_wdata = ram_rdata;
          j_d       = j_dec;
          if (j_q == CntW'(1)) begin
            state_d = S_SRT_PUT;
          end else begin
            ram_raddr = j_dec2[IdxW-1:0];
          end
        end else begin
          ram_wdata = key_q;
          idx_d     = idx_inc;
          state_d   = (idx_inc == count_q) ? S_HEAD_RD : S_SRT_RD;
        end
      end

      S_SRT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        idx_d     = idx_inc;
        state_d   = (idx_inc == count_q) ? S_HEAD_RD : S_SRT_RD;
      end

      S_HEAD_RD: begin
        ram_raddr = '0;
        state_d   = S_GRANT;
      end

      S_GRANT: begin
        key_d     = ram_rdata;
        granted_d = 1'b1;
        gid_d     = ID_PORT_W'(rd_id);
        if (mode_q == MODE_FCFS || count_q == CntW'(1)) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d     = CntW'(1);
          ram_raddr = IdxW'(1);
          state_d   = S_ROT;
        end
      end

      S_ROT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec[IdxW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_inc[IdxW-1:0];
        idx_d     = idx_inc;
        if (idx_inc == count_q) begin
          state_d = S_ROT_PUT;
        end
      end

      S_ROT_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = cnt_dec[IdxW-1:0];
        ram_wdata   = key_q;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FCFS;
      count_q     <= '0;
      term_q      <= '0;
      id_q        <= '0;
      idx_q       <= '0;
      w_q         <= '0;
      j_q         <= '0;
      key_q       <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      granted_q   <= 1'b0;
      gid_q       <= '0;
      rejected_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      term_q      <= term_d;
      id_q        <= id_d;
      idx_q       <= idx_d;
      w_q         <= w_d;
      j_q         <= j_d;
      key_q       <= key_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
      granted_q   <= granted_d;
      gid_q       <= gid_d;
      rejected_q  <= rejected_d;
    end
  end

  rqps_ram #(
    .WIDTH(WordW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign granted_o      = granted_q;
  assign granted_id_o   = gid_q;
  assign rejected_o     = rejected_q;

endmodule

>>> src/rqps_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqps_checker: port-level checks for the ready queue scheduler
// Watches the command and result ports over time.
// ---------------------------------------------------------------------------
module rqps_checker
  import rqps_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid_o,
  input logic                 granted_o,
  input logic [ID_PORT_W-1:0] granted_id_o,
  input logic                 rejected_o
);

  // a result word only shows once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // every result traces back to a command that was taken or still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(start && !busy)))
    else $error("result without a command");

  // a taken command either finishes next cycle or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("command dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !granted_o) |-> (granted_id_o == '0))
    else $error("id shown without grant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && granted_o) |-> !rejected_o)
    else $error("grant and reject together");

endmodule

bind ready_queue_process_scheduler rqps_checker u_rqps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .granted_o     (granted_o),
  .granted_id_o  (granted_id_o),
  .rejected_o    (rejected_o)
);
